### design/rmv_pkg.sv
// ---------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants of the running mean and variance block.
// ---------------------------------------------------------------------------
package rmv_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF    = 32;

   // fixed widths of the statistics and the result fields
   localparam int WIDE_BITS      = 64;
   localparam int SQ_IN_BITS     = 32;
   localparam int VAR_BITS       = 48;
   localparam int COUNT_OUT_BITS = 32;
   localparam int MEAN_OUT_BITS  = 32;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MEAN_DIV,
      ST_MEAN_WAIT,
      ST_SQ_DIV,
      ST_SQ_WAIT,
      ST_VAR_DIV,
      ST_VAR_WAIT,
      ST_OUT
   } state_type;

   // which operand goes to the divider
   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_SQ,
      DIV_VAR
   } div_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        load;
      logic        delta;
      logic        square;
      logic        div_start;
      div_sel_type div_sel;
      logic        upd_mean;
      logic        upd_sum;
      logic        upd_var;
      logic        load_out;
   } ctrl_cmd_type;

endpackage

### design/rmv_div.sv
// ---------------------------------------------------------------------------
// rmv_div
// Iterative restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rmv_div #(
   parameter int DVD_BITS = rmv_pkg::WIDE_BITS,
   parameter int DVS_BITS = rmv_pkg::COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                done,
   output logic [DVD_BITS-1:0] quotient,
   output logic [DVS_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DVD_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [DVS_BITS:0]   rem_shift;
   logic [DVS_BITS:0]   rem_diff;
   logic                fits;

   // one compare and subtract step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_BITS-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
   end

   // load on start, then shift one quotient bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DVD_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_BITS-2:0], fits};
         rem_in = fits ? rem_diff[DVS_BITS-1:0] : rem_shift[DVS_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### design/rmv_datapath.sv
// ---------------------------------------------------------------------------
// rmv_datapath
// Statistics registers, delta and square logic, shared divider and the
// result register.
// ---------------------------------------------------------------------------
module rmv_datapath #(
   parameter int SAMPLE_BITS   = rmv_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = rmv_pkg::FRACTION_BITS_DEF,
   parameter int COUNT_BITS    = rmv_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmv_pkg::ctrl_cmd_type               cmd,
   output logic                                div_done,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic [rmv_pkg::COUNT_OUT_BITS-1:0]  rsp_count,
   output logic [rmv_pkg::MEAN_OUT_BITS-1:0]   rsp_mean,
   output logic [rmv_pkg::VAR_BITS-1:0]        rsp_variance
);

   import rmv_pkg::*;

   localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;

   logic [MEAN_BITS-1:0]      sample_ff;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      first_ff, first_in;
   logic [MEAN_BITS-1:0]      mean_ff, mean_in;
   logic [WIDE_BITS-1:0]      sum_ff, sum_in;
   logic                      up_ff;
   logic [MEAN_BITS-1:0]      d_ff;
   logic [WIDE_BITS-1:0]      sq_ff;
   logic [VAR_BITS-1:0]       var_ff;
   logic [COUNT_OUT_BITS-1:0] out_count_ff;
   logic [MEAN_OUT_BITS-1:0]  out_mean_ff;
   logic [VAR_BITS-1:0]       out_var_ff;

   logic                      up_in;
   logic [MEAN_BITS-1:0]      d_in;
   logic [WIDE_BITS-1:0]      d_wide;
   logic [SQ_IN_BITS-1:0]     d_low;
   logic [WIDE_BITS-1:0]      sq_in;
   logic [WIDE_BITS-1:0]      div_dividend;
   logic [WIDE_BITS-1:0]      div_quo;
   logic [COUNT_BITS-1:0]     div_rem;
   logic [MEAN_BITS-1:0]      mean_step;
   logic [WIDE_BITS-1:0]      sq_ceil;
   logic [WIDE_BITS-1:0]      term;
   logic [WIDE_BITS:0]        sum_add;
   logic [VAR_BITS-1:0]       var_in;
   logic [WIDE_BITS-1:0]      mean_wide;
   logic [WIDE_BITS-1:0]      count_wide;

   // saturating count and first-sample flag
   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      if (cmd.load) begin
         first_in = count_ff == '0;
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // signed difference as magnitude and direction
   always_comb begin
      up_in = sample_ff >= mean_ff;
      d_in  = up_in ? (sample_ff - mean_ff) : (mean_ff - sample_ff);
   end

   // square of the magnitude, saturating when it exceeds the multiplier
   always_comb begin
      d_wide = WIDE_BITS'(d_ff);
      d_low  = d_wide[SQ_IN_BITS-1:0];
      if (d_wide[WIDE_BITS-1:SQ_IN_BITS] != '0) begin
         sq_in = '1;
      end else begin
         sq_in = WIDE_BITS'(d_low) * WIDE_BITS'(d_low);
      end
   end

   // pick the divider operand
   always_comb begin
      unique case (cmd.div_sel)
         DIV_MEAN: div_dividend = WIDE_BITS'(d_ff);
         DIV_SQ:   div_dividend = sq_ff;
         DIV_VAR:  div_dividend = sum_ff;
         default:  div_dividend = sum_ff;
      endcase
   end

   rmv_div #(
      .DVD_BITS (WIDE_BITS),
      .DVS_BITS (COUNT_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (count_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // mean update: first sample sets it, later ones move it by delta/k
   always_comb begin
      mean_step = div_quo[MEAN_BITS-1:0];
      mean_in   = mean_ff;
      if (cmd.upd_mean) begin
         if (first_ff) begin
            mean_in = sample_ff;
         end else if (up_ff) begin
            mean_in = mean_ff + mean_step;
         end else begin
            mean_in = mean_ff - mean_step;
         end
      end
   end

   // sum update: first sample clears it, later ones add floor((d*d - ceil(d*d/k)) / 2^F), saturating
   always_comb begin
      sq_ceil = div_quo + WIDE_BITS'(div_rem != '0);
      term    = (sq_ff - sq_ceil) >> FRACTION_BITS;
      sum_add = {1'b0, sum_ff} + {1'b0, term};
      sum_in  = sum_ff;
      if (cmd.upd_sum) begin
         if (first_ff) begin
            sum_in = '0;
         end else if (sum_add[WIDE_BITS]) begin
            sum_in = '1;
         end else begin
            sum_in = sum_add[WIDE_BITS-1:0];
         end
      end
   end

   // variance, saturating
   always_comb begin
      if (div_quo[WIDE_BITS-1:VAR_BITS] != '0) begin
         var_in = '1;
      end else begin
         var_in = div_quo[VAR_BITS-1:0];
      end
   end

   always_comb begin
      mean_wide  = WIDE_BITS'(mean_ff);
      count_wide = WIDE_BITS'(count_ff);
   end

   // statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= 1'b0;
         mean_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         mean_ff  <= mean_in;
         sum_ff   <= sum_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= {req_sample, FRACTION_BITS'(0)};
      end
      if (cmd.delta) begin
         up_ff <= up_in;
         d_ff  <= d_in;
      end
      if (cmd.square) begin
         sq_ff <= sq_in;
      end
      if (cmd.upd_var) begin
         var_ff <= var_in;
      end
      if (cmd.load_out) begin
         out_count_ff <= count_wide[COUNT_OUT_BITS-1:0];
         out_mean_ff  <= mean_wide[MEAN_OUT_BITS-1:0];
         out_var_ff   <= var_ff;
      end
   end

   assign rsp_count    = out_count_ff;
   assign rsp_mean     = out_mean_ff;
   assign rsp_variance = out_var_ff;

endmodule

### design/rmv_ctrl.sv
// ---------------------------------------------------------------------------
// rmv_ctrl
// Sequencer: steps one item through delta, three divisions and the
// result register, and owns both handshakes.
// ---------------------------------------------------------------------------
module rmv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  div_done,
   output rmv_pkg::ctrl_cmd_type cmd
);

   import rmv_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.div_sel  = DIV_MEAN;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
            cmd.square    = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               cmd.upd_mean = 1'b1;
               state_in     = ST_SQ_DIV;
            end
         end
         ST_SQ_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SQ;
            state_in      = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (div_done) begin
               cmd.upd_sum = 1'b1;
               state_in    = ST_VAR_DIV;
            end
         end
         ST_VAR_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
            state_in      = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_done) begin
               cmd.upd_var = 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/running_mean_variance.sv
// ---------------------------------------------------------------------------
// running_mean_variance
// Welford running count, mean and population variance of a sample stream.
// ---------------------------------------------------------------------------
//
//   channel   ports                                     direction
//   request   req_valid, req_stall, req_sample          in
//   response  rsp_valid, rsp_stall, rsp_count,          out
//             rsp_mean, rsp_variance
//
// Each item passes accept, delta, then three 64-step divisions by the
// count (delta/k, square/k, sum/k), run one after another on a single
// one-bit-per-cycle restoring divider, each with a divider start and a
// step to take the quotient, and last the result load.
// One item is in work at a time; the next one is taken while the result
// register still waits for the consumer.
// Reset clears the count, mean, sum and both handshakes.
// A stalled response holds; a finished item waits until the result
// register frees.
// ---------------------------------------------------------------------------
module running_mean_variance #(
   parameter int SAMPLE_BITS   = rmv_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = rmv_pkg::FRACTION_BITS_DEF,
   parameter int COUNT_BITS    = rmv_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rmv_pkg::COUNT_OUT_BITS-1:0] rsp_count,
   output logic [rmv_pkg::MEAN_OUT_BITS-1:0]  rsp_mean,
   output logic [rmv_pkg::VAR_BITS-1:0]       rsp_variance
);

   import rmv_pkg::*;

   ctrl_cmd_type cmd;
   logic         div_done;

   rmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .div_done  (div_done),
      .cmd       (cmd)
   );

   rmv_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .div_done     (div_done),
      .req_sample   (req_sample),
      .rsp_count    (rsp_count),
      .rsp_mean     (rsp_mean),
      .rsp_variance (rsp_variance)
   );

endmodule

### design/rmv_checker.sv
// ---------------------------------------------------------------------------
// rmv_checker
// Port-level checks of the running mean and variance block.
// ---------------------------------------------------------------------------
module rmv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [rmv_pkg::COUNT_OUT_BITS-1:0] rsp_count,
   input logic [rmv_pkg::MEAN_OUT_BITS-1:0]  rsp_mean,
   input logic [rmv_pkg::VAR_BITS-1:0]       rsp_variance
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_count) && $stable(rsp_mean) && $stable(rsp_variance))
      else $error("stalled response changed");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // every result counts at least one sample
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != '0)
      else $error("response with zero count");

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_count    (rsp_count),
   .rsp_mean     (rsp_mean),
   .rsp_variance (rsp_variance)
);
